/* rtl/core/ppab_pkg.sv */
// shared types, register codes and channel helpers for the packed pixel blend
`timescale 1ns / 1ps

package ppab_pkg;

    localparam int PIXEL_WIDTH_DEF = 32;
    localparam int NUM_CHAN        = 3;
    localparam int PIPE_DEPTH      = 4;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [2:0] REG_RED_SHIFT   = 3'd0;
    localparam logic [2:0] REG_RED_WIDTH   = 3'd1;
    localparam logic [2:0] REG_GREEN_SHIFT = 3'd2;
    localparam logic [2:0] REG_GREEN_WIDTH = 3'd3;
    localparam logic [2:0] REG_BLUE_SHIFT  = 3'd4;
    localparam logic [2:0] REG_BLUE_WIDTH  = 3'd5;

    localparam logic [7:0] WEIGHT_ZERO = 8'd0;
    localparam logic [7:0] WEIGHT_FULL = 8'd255;
    localparam logic [3:0] CHAN_BITS   = 4'd8;

    typedef struct packed {
        logic [4:0] shift;
        logic [3:0] width;
    } ppab_chan_cfg_t;

    // widths above eight saturate
    function automatic logic [3:0] eff_width(input logic [3:0] w);
        return (w > CHAN_BITS) ? CHAN_BITS : w;
    endfunction

    // pull one channel out and stretch it to 8 bits by repeating its top bits
    function automatic logic [7:0] widen8(input logic [31:0] word,
                                          input logic [4:0]  shift,
                                          input logic [3:0]  w);
        logic [31:0] sh;
        logic [7:0]  v;
        logic [7:0]  a;
        sh = word >> shift;
        v  = sh[7:0] & (8'hFF >> (CHAN_BITS - w));
        a  = v << (CHAN_BITS - w);
        return a | (a >> w);
    endfunction

endpackage

/* rtl/core/packed_pixel_alpha_blend_core.sv */
// packed rgb alpha blend core: four-stage pipeline with configurable layout
`timescale 1ns / 1ps

// Blends a foreground pixel over a background pixel with an 8-bit weight.
// Input channel: in_valid / in_ready with background, foreground, weight.
// Output channel: out_valid / out_ready with blended.
// Config channel: cfg_valid / cfg_ready (always high) with cfg_index and
// cfg_data; indexes 0..5 set red, green, blue shift and width, others are
// dropped. Write config only while no pixel is in flight.
// Each pixel passes the stages in order: widen, multiply, divide by 255 and
// mix, then repack into the output register.
// Throughput is one pixel per cycle while out_ready stays high; every stage
// has its own valid bit and advances when the stage after it is empty or moving.
// When the receiver holds out_ready low the stages fill up behind the
// output register and in_ready drops once all four are occupied; nothing
// is lost or repeated.
// Reset empties the pipeline and sets the layout to red at 16, green at 8,
// blue at 0, all eight bits wide.
module packed_pixel_alpha_blend_core
    import ppab_pkg::*;
#(
    parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] background,
    input  logic [31:0] foreground,
    input  logic [7:0]  weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] blended,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    ppab_chan_cfg_t chan_cfg_reg [NUM_CHAN];

    // stage 1: widened channels
    logic                   v1_reg;
    logic [PIXEL_WIDTH-1:0] bg1_reg, fg1_reg;
    logic                   sel_bg1_reg, sel_fg1_reg;
    logic [7:0]             t1_reg;
    logic [7:0]             base1_reg [NUM_CHAN];
    logic [7:0]             mag1_reg  [NUM_CHAN];
    logic                   neg1_reg  [NUM_CHAN];

    // stage 2: products
    logic                   v2_reg;
    logic [PIXEL_WIDTH-1:0] bg2_reg, fg2_reg;
    logic                   sel_bg2_reg, sel_fg2_reg;
    logic [7:0]             base2_reg [NUM_CHAN];
    logic [15:0]            prod2_reg [NUM_CHAN];
    logic                   neg2_reg  [NUM_CHAN];

    // stage 3: mixed 8-bit channels
    logic                   v3_reg;
    logic [PIXEL_WIDTH-1:0] bg3_reg, fg3_reg;
    logic                   sel_bg3_reg, sel_fg3_reg;
    logic [7:0]             mix3_reg [NUM_CHAN];

    // stage 4: output register
    logic                   v4_reg;
    logic [PIXEL_WIDTH-1:0] pix4_reg;

    logic rdy1, rdy2, rdy3, rdy4;

    logic [PIXEL_WIDTH-1:0] bg_in, fg_in;
    logic [7:0]             base_in [NUM_CHAN];
    logic [7:0]             mag_in  [NUM_CHAN];
    logic                   neg_in  [NUM_CHAN];
    logic [15:0]            prod_next [NUM_CHAN];
    logic [7:0]             mix_next  [NUM_CHAN];
    logic [PIXEL_WIDTH-1:0] pix_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign cfg_ready = 1'b1;
    assign out_valid = v4_reg;
    assign blended   = 32'(pix4_reg);

    assign bg_in = background[PIXEL_WIDTH-1:0];
    assign fg_in = foreground[PIXEL_WIDTH-1:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cfg_reg[CH_RED]   <= '{shift: 5'd16, width: 4'd8};
            chan_cfg_reg[CH_GREEN] <= '{shift: 5'd8,  width: 4'd8};
            chan_cfg_reg[CH_BLUE]  <= '{shift: 5'd0,  width: 4'd8};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RED_SHIFT:   chan_cfg_reg[CH_RED].shift   <= cfg_data;
                REG_RED_WIDTH:   chan_cfg_reg[CH_RED].width   <= cfg_data[3:0];
                REG_GREEN_SHIFT: chan_cfg_reg[CH_GREEN].shift <= cfg_data;
                REG_GREEN_WIDTH: chan_cfg_reg[CH_GREEN].width <= cfg_data[3:0];
                REG_BLUE_SHIFT:  chan_cfg_reg[CH_BLUE].shift  <= cfg_data;
                REG_BLUE_WIDTH:  chan_cfg_reg[CH_BLUE].width  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // stage 1 logic: extract, widen, signed difference as magnitude and sign
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            logic [7:0] b8;
            logic [7:0] f8;
            logic [3:0] w;
            w          = eff_width(chan_cfg_reg[c].width);
            b8         = widen8(32'(bg_in), chan_cfg_reg[c].shift, w);
            f8         = widen8(32'(fg_in), chan_cfg_reg[c].shift, w);
            base_in[c] = b8;
            neg_in[c]  = f8 < b8;
            mag_in[c]  = (f8 < b8) ? (b8 - f8) : (f8 - b8);
        end
    end

    // stage 2 logic: one 8x8 multiply per channel
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            prod_next[c] = 16'(mag1_reg[c]) * 16'(t1_reg);
        end
    end

    // stage 3 logic: x / 255 as (x + 1 + (x >> 8)) >> 8, exact below 65280 as q keeps 8 bits
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            logic [16:0] acc;
            logic [7:0]  q;
            logic [8:0]  sum;
            acc = 17'(prod2_reg[c]) + 17'd1 + 17'(prod2_reg[c] >> 8);
            q   = acc[15:8];
            sum = neg2_reg[c] ? (9'(base2_reg[c]) - 9'(q))
                              : (9'(base2_reg[c]) + 9'(q));
            mix_next[c] = sum[7:0];
        end
    end

    // stage 4 logic: cut back to width, place, merge; bypass for end weights
    always_comb
    begin
        logic [PIXEL_WIDTH-1:0] acc;
        acc = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            logic [3:0]             w;
            logic [7:0]             v;
            logic [PIXEL_WIDTH+7:0] placed;
            w      = eff_width(chan_cfg_reg[c].width);
            v      = mix3_reg[c] >> (CHAN_BITS - w);
            placed = (PIXEL_WIDTH+8)'(v) << chan_cfg_reg[c].shift;
            acc    = acc | placed[PIXEL_WIDTH-1:0];
        end
        if (sel_bg3_reg)
            pix_next = bg3_reg;
        else if (sel_fg3_reg)
            pix_next = fg3_reg;
        else
            pix_next = acc;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            bg1_reg     <= bg_in;
            fg1_reg     <= fg_in;
            sel_bg1_reg <= weight == WEIGHT_ZERO;
            sel_fg1_reg <= weight == WEIGHT_FULL;
            t1_reg      <= weight;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                base1_reg[c] <= base_in[c];
                mag1_reg[c]  <= mag_in[c];
                neg1_reg[c]  <= neg_in[c];
            end
        end
        if (rdy2 && v1_reg)
        begin
            bg2_reg     <= bg1_reg;
            fg2_reg     <= fg1_reg;
            sel_bg2_reg <= sel_bg1_reg;
            sel_fg2_reg <= sel_fg1_reg;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                base2_reg[c] <= base1_reg[c];
                prod2_reg[c] <= prod_next[c];
                neg2_reg[c]  <= neg1_reg[c];
            end
        end
        if (rdy3 && v2_reg)
        begin
            bg3_reg     <= bg2_reg;
            fg3_reg     <= fg2_reg;
            sel_bg3_reg <= sel_bg2_reg;
            sel_fg3_reg <= sel_fg2_reg;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                mix3_reg[c] <= mix_next[c];
            end
        end
        if (rdy4 && v3_reg)
        begin
            pix4_reg <= pix_next;
        end
    end

endmodule

/* rtl/core/ppab_checker.sv */
// port-level checker for the packed pixel blend core, bound into the core module
`timescale 1ns / 1ps

module ppab_checker
    import ppab_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] blended,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // pixels accepted but not yet delivered
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_valid && in_ready)
            inflight_next = inflight_next + 3'd1;
        if (out_valid && out_ready)
            inflight_next = inflight_next - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blended))
        else $error("blended beat changed while stalled");

    a_full_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input back-pressure without output stall");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("output beat with no pixel in flight");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind packed_pixel_alpha_blend_core ppab_checker u_ppab_checker (.*);
